### design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Field widths, character and mode codes, the command word passed from the
// front end to the back end, and the result word.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // fixed port field widths
   localparam int MODE_W = 2;
   localparam int CHAR_W = 8;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int ATTR_W = 8;
   localparam int CELL_W = 16;

   // default screen geometry
   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   // depth of the queues between the parts
   localparam int FIFO_DEPTH = 2;

   // mode codes
   localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   // control characters
   localparam logic [CHAR_W-1:0] CH_NUL = 8'd0;
   localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NL  = 8'd10;

   // cell used to fill the bottom row after a scroll, attribute at reset
   localparam logic [CELL_W-1:0] SCROLL_FILL = 16'h0720;
   localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'd7;

   // back end operations
   typedef enum logic [2:0] {
      OP_NOP,
      OP_WRITE,
      OP_BACK,
      OP_TAB,
      OP_NEWLINE,
      OP_READ,
      OP_CLEAR
   } op_type;

   // classified command word
   typedef struct packed {
      op_type              op;
      logic [CHAR_W-1:0]   char_code;
      logic [ROW_W-1:0]    read_row;
      logic [COL_W-1:0]    read_col;
   } cmd_type;

   // result word
   typedef struct packed {
      logic [ROW_W-1:0]    cursor_row;
      logic [COL_W-1:0]    cursor_col;
      logic [CELL_W-1:0]   cell_data;
   } rsp_type;

   // back end sequencer states
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ_WAIT,
      ST_BS_READ,
      ST_BS_DECIDE,
      ST_SCROLL,
      ST_FILL,
      ST_CLEAR,
      ST_REPLY
   } state_type;

endpackage

### design/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core: character cell console engine
// Keeps a COLUMNS x ROWS store of 16-bit cells (attribute, character) and a
// cursor. Each input word puts a character, reads a cell or clears the
// screen, and yields exactly one result word with the cursor position.
//
// Input words enter while full is low (push), results leave while empty is
// low (pop). A small command queue sits between the classifier and the
// sequencer, and a result queue sits at the output, so the input side keeps
// taking words while a result waits to be popped.
// A scroll walks the whole store through the separate read and write ports
// of the memory, and a clear sweeps it too. The sequencer runs one word at
// a time. After reset the store is cleared one cell per cycle with full held
// high; the attribute register reads 7 and may be written at any time the
// block is idle. When pop stays low the result queue fills, the sequencer
// holds, then the command queue fills and full rises; no word is lost.
// ----------------------------------------------------------------------------
module text_console_writer_core
   import tcw_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  logic              clock,
   input  logic              reset,
   // configuration
   input  logic              csr_we,
   input  logic [ATTR_W-1:0] csr_wdata,
   // input words
   input  logic              push,
   output logic              full,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic [ROW_W-1:0]  req_read_row,
   input  logic [COL_W-1:0]  req_read_col,
   // result words
   output logic              empty,
   input  logic              pop,
   output logic [ROW_W-1:0]  rsp_cursor_row,
   output logic [COL_W-1:0]  rsp_cursor_col,
   output logic [CELL_W-1:0] rsp_cell_data
);

   logic [ATTR_W-1:0] attr_ff, attr_in;
   cmd_type           cmd;
   logic              cmd_empty, cmd_pop;
   rsp_type           rsp_new, rsp_head;
   logic              rsp_push, rsp_full;
   logic              init_busy;

   // attribute register
   assign attr_in = csr_we ? csr_wdata : attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
      end else begin
         attr_ff <= attr_in;
      end
   end

   tcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .busy      (init_busy),
      .push      (push),
      .full      (full),
      .mode      (req_mode),
      .char_code (req_char_code),
      .read_row  (req_read_row),
      .read_col  (req_read_col),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .cmd_empty (cmd_empty)
   );

   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .attr      (attr_ff),
      .cmd       (cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp       (rsp_new),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full),
      .init_busy (init_busy)
   );

   tcw_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .din   (rsp_new),
      .pop   (pop),
      .dout  (rsp_head),
      .full  (rsp_full),
      .empty (empty)
   );

   assign rsp_cursor_row = rsp_head.cursor_row;
   assign rsp_cursor_col = rsp_head.cursor_col;
   assign rsp_cell_data  = rsp_head.cell_data;

endmodule

### design/tcw_fifo.sv
// ----------------------------------------------------------------------------
// tcw_fifo: small register queue
// Holds DEPTH words; head word is shown while not empty.
// ----------------------------------------------------------------------------
module tcw_fifo
   import tcw_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = FIFO_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             full,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in;
   logic [PW-1:0]    rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign dout    = slot_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and count update
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + PW'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= din;
      end
   end

endmodule

### design/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front: input word classifier
// Decodes mode and character into a back end operation and queues it.
// ----------------------------------------------------------------------------
module tcw_front
   import tcw_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              busy,
   input  logic              push,
   output logic              full,
   input  logic [MODE_W-1:0] mode,
   input  logic [CHAR_W-1:0] char_code,
   input  logic [ROW_W-1:0]  read_row,
   input  logic [COL_W-1:0]  read_col,
   input  logic              cmd_pop,
   output cmd_type           cmd,
   output logic              cmd_empty
);

   cmd_type cmd_new;
   logic    q_full;
   logic    in_range;

   // reads outside the screen return zero and behave as no-ops
   assign in_range = (32'(read_row) < 32'(ROWS)) && (32'(read_col) < 32'(COLUMNS));

   // classify
   always_comb begin
      cmd_new.char_code = char_code;
      cmd_new.read_row  = read_row;
      cmd_new.read_col  = read_col;
      unique case (mode)
         MODE_PUT: begin
            unique case (char_code)
               CH_NUL:  cmd_new.op = OP_NOP;
               CH_BS:   cmd_new.op = OP_BACK;
               CH_TAB:  cmd_new.op = OP_TAB;
               CH_NL:   cmd_new.op = OP_NEWLINE;
               default: cmd_new.op = OP_WRITE;
            endcase
         end
         MODE_READ:  cmd_new.op = in_range ? OP_READ : OP_NOP;
         MODE_CLEAR: cmd_new.op = OP_CLEAR;
         default:    cmd_new.op = OP_NOP;
      endcase
   end

   assign full = q_full || busy;

   tcw_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (FIFO_DEPTH)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push && !full),
      .din   (cmd_new),
      .pop   (cmd_pop),
      .dout  (cmd),
      .full  (q_full),
      .empty (cmd_empty)
   );

endmodule

### design/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back: screen store and command sequencer
// Owns the cell memory and cursor; runs writes, reads, backspace, scroll
// and clear sweeps, then posts one result word per command.
// ----------------------------------------------------------------------------
module tcw_back
   import tcw_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [ATTR_W-1:0] attr,
   input  cmd_type           cmd,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   output rsp_type           rsp,
   output logic              rsp_push,
   input  logic              rsp_full,
   output logic              init_busy
);

   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int CW1   = CW + 1;
   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);

   localparam logic [AW-1:0]  LAST_CELL = AW'(CELLS - 1);
   localparam logic [AW-1:0]  MOVE_CNT  = AW'((ROWS - 1) * COLUMNS);
   localparam logic [AW-1:0]  ROW_STEP  = AW'(COLUMNS);
   localparam logic [CW-1:0]  LAST_COL  = CW'(COLUMNS - 1);
   localparam logic [CW1-1:0] LAST_COL1 = CW1'(COLUMNS - 1);
   localparam logic [RW-1:0]  LAST_ROW  = RW'(ROWS - 1);

   // cell memory
   logic [CELL_W-1:0] mem [CELLS];
   logic [CELL_W-1:0] rd_data_ff;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic              wr_en;

   state_type         state_ff, state_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [AW-1:0]     dst_ff, dst_in;
   logic              pend_ff, pend_in;
   logic              armed_ff, armed_in;
   logic              extra_ff, extra_in;
   logic              first_ff, first_in;
   logic [CELL_W-1:0] data_ff, data_in;

   logic [AW-1:0]     cur_pos, read_pos;
   logic [CW1-1:0]    tab_col;
   logic              at_home, prev_zero, go, do_nl;

   assign cur_pos  = AW'(row_ff) * ROW_STEP + AW'(col_ff);
   assign read_pos = AW'(cmd.read_row) * ROW_STEP + AW'(cmd.read_col);
   assign tab_col  = {1'b0, (col_ff | CW'(1))} + CW1'(1);
   assign at_home  = (row_ff == '0) && (col_ff == '0);
   assign prev_zero = at_home || (rd_data_ff == '0);

   assign rsp.cursor_row = ROW_W'(row_ff);
   assign rsp.cursor_col = COL_W'(col_ff);
   assign rsp.cell_data  = data_ff;
   assign init_busy      = (state_ff == ST_INIT);

   // sequencer
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      idx_in   = idx_ff;
      dst_in   = idx_ff;
      pend_in  = 1'b0;
      armed_in = armed_ff;
      extra_in = extra_ff;
      first_in = first_ff;
      data_in  = data_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = '0;
      rd_addr  = idx_ff;
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      go       = 1'b0;
      do_nl    = 1'b0;

      unique case (state_ff)
         // clearing pass after reset
         ST_INIT: begin
            wr_en  = 1'b1;
            idx_in = idx_ff + AW'(1);
            if (idx_ff == LAST_CELL) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            idx_in   = '0;
            first_in = 1'b1;
            extra_in = 1'b1;
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               data_in = '0;
               unique case (cmd.op)
                  OP_NOP: state_in = ST_REPLY;
                  OP_WRITE: begin
                     wr_en   = 1'b1;
                     wr_addr = cur_pos;
                     wr_data = {attr, cmd.char_code};
                     if (col_ff == LAST_COL) begin
                        do_nl = 1'b1;
                     end else begin
                        col_in   = col_ff + CW'(1);
                        state_in = ST_REPLY;
                     end
                  end
                  OP_TAB: begin
                     if (tab_col > LAST_COL1) begin
                        do_nl = 1'b1;
                     end else begin
                        col_in   = CW'(tab_col);
                        state_in = ST_REPLY;
                     end
                  end
                  OP_NEWLINE: do_nl = 1'b1;
                  OP_BACK:    state_in = ST_BS_READ;
                  OP_READ: begin
                     rd_addr  = read_pos;
                     state_in = ST_READ_WAIT;
                  end
                  OP_CLEAR: begin
                     row_in   = '0;
                     col_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: state_in = ST_REPLY;
               endcase
            end
         end

         ST_READ_WAIT: begin
            data_in  = rd_data_ff;
            state_in = ST_REPLY;
         end

         // fetch the cell before the cursor
         ST_BS_READ: begin
            rd_addr  = cur_pos - AW'(1);
            state_in = ST_BS_DECIDE;
         end

         // decide on one erase step
         ST_BS_DECIDE: begin
            if (first_ff) begin
               first_in = 1'b0;
               armed_in = prev_zero;
               if (!prev_zero) begin
                  extra_in = 1'b0;
               end
               go = 1'b1;
            end else if (prev_zero && armed_ff) begin
               go = 1'b1;
            end else begin
               go       = extra_ff;
               extra_in = 1'b0;
            end
            if (!go || at_home) begin
               state_in = ST_REPLY;
            end else begin
               wr_en   = 1'b1;
               wr_addr = cur_pos - AW'(1);
               if (col_ff != '0) begin
                  col_in = col_ff - CW'(1);
               end else begin
                  col_in = LAST_COL;
                  row_in = row_ff - RW'(1);
               end
               state_in = ST_BS_READ;
            end
         end

         // move each row up: read one row ahead, write each cell in the cycle after its read
         ST_SCROLL: begin
            rd_addr = idx_ff + ROW_STEP;
            if (idx_ff != MOVE_CNT) begin
               idx_in  = idx_ff + AW'(1);
               pend_in = 1'b1;
            end else begin
               state_in = ST_FILL;
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = dst_ff;
               wr_data = rd_data_ff;
            end
         end

         ST_FILL: begin
            wr_en   = 1'b1;
            wr_data = SCROLL_FILL;
            idx_in  = idx_ff + AW'(1);
            if (idx_ff == LAST_CELL) begin
               state_in = ST_REPLY;
            end
         end

         ST_CLEAR: begin
            wr_en  = 1'b1;
            idx_in = idx_ff + AW'(1);
            if (idx_ff == LAST_CELL) begin
               state_in = ST_REPLY;
            end
         end

         ST_REPLY: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // line feed: wrap column, advance row or start scroll
      if (do_nl) begin
         col_in = '0;
         if (row_ff == LAST_ROW) begin
            state_in = ST_SCROLL;
         end else begin
            row_in   = row_ff + RW'(1);
            state_in = ST_REPLY;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         row_ff   <= '0;
         col_ff   <= '0;
         idx_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         idx_ff   <= idx_in;
         pend_ff  <= pend_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      dst_ff   <= dst_in;
      armed_ff <= armed_in;
      extra_ff <= extra_in;
      first_ff <= first_in;
      data_ff  <= data_in;
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // cursor always on screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= LAST_COL) && (row_ff <= LAST_ROW))
      else $error("cursor left the screen");

   // last row move must still be in flight when the scroll ends
   a_scroll_tail: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCROLL) && (idx_ff == MOVE_CNT) |-> pend_ff)
      else $error("scroll ended without its last row write");

   // results only go into a queue with room
   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into a full queue");

   // reset always starts the clearing pass
   a_reset_init: assert property (@(posedge clock)
      reset |=> (state_ff == ST_INIT))
      else $error("reset did not start the clearing pass");

endmodule
